// ----- src/mlr_pkg.sv -----
// ----------------------------------------------------------------------------
// Midpoint line rasterizer package
// Shared types, codes and small helpers used by the front end, the command
// queue and the walker.
// ----------------------------------------------------------------------------
package mlr_pkg;

  // Fixed widths of the item fields
  localparam int unsigned IN_W       = 11;
  localparam int unsigned COLOUR_W   = 24;
  localparam int unsigned OUT_XY_W   = 13;

  // Thick spans are five pixels across the major axis
  localparam int unsigned SPAN_LEN   = 5;
  localparam int unsigned SPAN_IDX_W = 3;

  // Entries in the command queue between front and back (power of two)
  localparam int unsigned QUEUE_DEPTH = 2;

  // Item kinds
  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_e;

  // Line classes after ordering the endpoints by x
  typedef enum logic [2:0] {
    OCT_VERT       = 3'd0,
    OCT_SHALLOW_DN = 3'd1,
    OCT_STEEP_DN   = 3'd2,
    OCT_SHALLOW_UP = 3'd3,
    OCT_STEEP_UP   = 3'd4
  } octant_e;

  // Fixed-width part of a queued command
  typedef struct packed {
    kind_e               kind;
    logic                thick;
    octant_e             octant;
    logic [COLOUR_W-1:0] colour;
  } cmd_ctrl_t;

  // Offset across the major axis for each pixel of a thick span
  function automatic logic signed [2:0] span_offset(input logic [SPAN_IDX_W-1:0] idx);
    logic signed [2:0] off;
    case (idx)
      3'd0:    off = 3'sd0;
      3'd1:    off = 3'sd1;
      3'd2:    off = 3'sd2;
      3'd3:    off = -3'sd1;
      3'd4:    off = -3'sd2;
      default: off = 3'sd0;
    endcase
    return off;
  endfunction

  // Shallow lines walk along x, all others along y
  function automatic logic is_shallow(input octant_e oct);
    return (oct == OCT_SHALLOW_DN) || (oct == OCT_SHALLOW_UP);
  endfunction

endpackage

// ----- src/midpoint_line_rasterizer.sv -----
// Path of an item: front-end stage register, command queue, walker position register.
// Throughput: one item per cycle in thin mode when the output is not stalled; in thick mode
//   each position is a five-pixel span, sent in full before the walker takes the next item.
// Items are accepted while pixels wait: a two-entry command queue separates the two halves.
// Reset: asynchronous, clears thick mode, the queue and the walker to idle.
// ----------------------------------------------------------------------------
// Midpoint line rasterizer
// Integer line walker with an optional five-pixel thick mode.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer
  import mlr_pkg::*;
#(
  parameter int COORD_WIDTH = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  // item channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic [IN_W-1:0]     x_start_i,
  input  logic [IN_W-1:0]     y_start_i,
  input  logic [IN_W-1:0]     x_end_i,
  input  logic [IN_W-1:0]     y_end_i,
  input  logic [COLOUR_W-1:0] colour_i,
  // pixel channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [OUT_XY_W-1:0] pixel_x_o,
  output logic [OUT_XY_W-1:0] pixel_y_o,
  output logic [COLOUR_W-1:0] pixel_colour_o,
  output logic                last_of_item_o,
  output logic                line_done_o
);

  localparam int CMD_W = $bits(cmd_ctrl_t) + 3 * (COORD_WIDTH + 1) + 3 * (COORD_WIDTH + 4);

  logic             thick_mode_q;
  logic             push, pop, full, empty;
  logic [CMD_W-1:0] cmd_wr, cmd_rd;

  // Hold the thick mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thick_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      thick_mode_q <= cfg_wdata_i;
    end
  end

  mlr_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .colour_i     (colour_i),
    .thick_mode_i (thick_mode_q),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (cmd_wr)
  );

  mlr_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_wr),
    .pop_i   (pop),
    .rdata_o (cmd_rd),
    .full_o  (full),
    .empty_o (empty)
  );

  mlr_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_rd),
    .empty_i        (empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .pixel_colour_o (pixel_colour_o),
    .last_of_item_o (last_of_item_o),
    .line_done_o    (line_done_o)
  );

endmodule

// ----- src/mlr_front.sv -----
// ----------------------------------------------------------------------------
// Midpoint line rasterizer front end
// Accepts items, orders the endpoints by x, classifies the line and works out
// the start decision value, increments, first position and walk limit.
// ----------------------------------------------------------------------------
module mlr_front
  import mlr_pkg::*;
#(
  parameter int COORD_WIDTH = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // item channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 kind_i,
  input  logic [IN_W-1:0]      x_start_i,
  input  logic [IN_W-1:0]      y_start_i,
  input  logic [IN_W-1:0]      x_end_i,
  input  logic [IN_W-1:0]      y_end_i,
  input  logic [COLOUR_W-1:0]  colour_i,
  input  logic                 thick_mode_i,
  // command queue write side
  input  logic                 full_i,
  output logic                 push_o,
  output logic [$bits(cmd_ctrl_t)+3*(COORD_WIDTH+1)+3*(COORD_WIDTH+4)-1:0] cmd_o
);

  localparam int IW    = (COORD_WIDTH - 1 < IN_W) ? COORD_WIDTH - 1 : IN_W;
  localparam int POS_W = COORD_WIDTH + 1;
  localparam int DEC_W = COORD_WIDTH + 4;

  // Stage register: ordered endpoints and deltas
  logic                    s1_valid_q;
  kind_e                   s1_kind_q;
  logic                    s1_thick_q;
  logic [COLOUR_W-1:0]     s1_colour_q;
  logic [IW-1:0]           s1_xa_q, s1_ya_q, s1_xb_q, s1_yb_q;
  logic signed [IW:0]      s1_a_q;
  logic [IW-1:0]           s1_b_q;

  logic                    in_xfer;
  logic                    s1_free;
  logic [IW-1:0]           xs, ys, xe, ye;
  logic                    swap;
  logic [IW-1:0]           xa_d, ya_d, xb_d, yb_d;
  logic signed [IW:0]      a_d;

  assign s1_free    = !s1_valid_q || !full_i;
  assign in_stall_o = !s1_free;
  assign in_xfer    = in_valid_i && s1_free;
  assign push_o     = s1_valid_q && !full_i;

  // Order endpoints by x
  always_comb begin
    xs   = x_start_i[IW-1:0];
    ys   = y_start_i[IW-1:0];
    xe   = x_end_i[IW-1:0];
    ye   = y_end_i[IW-1:0];
    swap = xe < xs;
    xa_d = swap ? xe : xs;
    ya_d = swap ? ye : ys;
    xb_d = swap ? xs : xe;
    yb_d = swap ? ys : ye;
    a_d  = $signed((IW + 1)'(yb_d)) - $signed((IW + 1)'(ya_d));
  end

  // Hold the stage valid until the queue takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_kind_q   <= kind_e'(kind_i);
      s1_thick_q  <= thick_mode_i;
      s1_colour_q <= colour_i;
      s1_xa_q     <= xa_d;
      s1_ya_q     <= ya_d;
      s1_xb_q     <= xb_d;
      s1_yb_q     <= yb_d;
      s1_a_q      <= a_d;
      s1_b_q      <= xb_d - xa_d;
    end
  end

  // Classify and set up the walk
  cmd_ctrl_t               ctrl;
  logic signed [DEC_W-1:0] a_x, b_x, neg_b, a2, b2;
  logic signed [DEC_W-1:0] dec_init, inc_keep, inc_move;
  logic signed [POS_W-1:0] xa_p, ya_p, xb_p, yb_p, lo_p, hi_p;
  logic signed [POS_W-1:0] px, py, end_p, limit;
  octant_e                 oct;

  always_comb begin
    a_x   = DEC_W'(s1_a_q);
    b_x   = $signed(DEC_W'(s1_b_q));
    neg_b = -b_x;
    a2    = a_x <<< 1;
    b2    = b_x <<< 1;
    xa_p  = $signed(POS_W'(s1_xa_q));
    ya_p  = $signed(POS_W'(s1_ya_q));
    xb_p  = $signed(POS_W'(s1_xb_q));
    yb_p  = $signed(POS_W'(s1_yb_q));
    lo_p  = (ya_p < yb_p) ? ya_p : yb_p;
    hi_p  = (ya_p < yb_p) ? yb_p : ya_p;

    if (s1_b_q == '0) begin
      oct = OCT_VERT;
    end else if (!a_x[DEC_W-1] && (a_x <= b_x)) begin
      oct = OCT_SHALLOW_DN;
    end else if (a_x > b_x) begin
      oct = OCT_STEEP_DN;
    end else if (a_x >= neg_b) begin
      oct = OCT_SHALLOW_UP;
    end else begin
      oct = OCT_STEEP_UP;
    end

    dec_init = '0;
    inc_keep = '0;
    inc_move = '0;
    px       = xa_p;
    py       = ya_p;
    end_p    = hi_p;
    case (oct)
      OCT_VERT: begin
        py    = s1_thick_q ? lo_p - POS_W'(1) : lo_p;
        end_p = hi_p;
      end
      OCT_SHALLOW_DN: begin
        dec_init = b_x - a2;
        inc_keep = -a2;
        inc_move = b2 - a2;
        end_p    = xb_p;
      end
      OCT_STEEP_DN: begin
        dec_init = a_x - b2;
        inc_keep = -b2;
        inc_move = a2 - b2;
        end_p    = yb_p;
      end
      OCT_SHALLOW_UP: begin
        dec_init = a2 + b_x;
        inc_keep = a2;
        inc_move = a2 + b2;
        end_p    = xb_p;
      end
      OCT_STEEP_UP: begin
        dec_init = a_x + b2;
        inc_keep = -b2;
        inc_move = -a2 - b2;
        px       = xb_p;
        py       = yb_p;
        end_p    = ya_p;
      end
      default: begin
        dec_init = '0;
      end
    endcase
    // Thick walks run one past the far end
    limit = s1_thick_q ? end_p + POS_W'(1) : end_p;

    ctrl.kind   = s1_kind_q;
    ctrl.thick  = s1_thick_q;
    ctrl.octant = oct;
    ctrl.colour = s1_colour_q;
    cmd_o = {ctrl, px, py, limit, dec_init, inc_keep, inc_move};
  end

endmodule

// ----- src/mlr_queue.sv -----
// ----------------------------------------------------------------------------
// Midpoint line rasterizer command queue
// Short first-in first-out queue that decouples the front end from the walker.
// ----------------------------------------------------------------------------
module mlr_queue
  import mlr_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH) + 1;

  logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;

  assign empty_o = wr_ptr_q == rd_ptr_q;
  assign full_o  = (wr_ptr_q[PTR_W-1] != rd_ptr_q[PTR_W-1]) &&
                   (wr_ptr_q[PTR_W-2:0] == rd_ptr_q[PTR_W-2:0]);
  assign rdata_o = entry_q[rd_ptr_q[PTR_W-2:0]];

  // Advance pointers on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q[PTR_W-2:0]] <= wdata_i;
    end
  end

endmodule

// ----- src/mlr_back.sv -----
// ----------------------------------------------------------------------------
// Midpoint line rasterizer walker
// Carries out queued commands: loads or advances the walk, makes the midpoint
// decision and sends each position out as one pixel or a five-pixel span.
// ----------------------------------------------------------------------------
module mlr_back
  import mlr_pkg::*;
#(
  parameter int COORD_WIDTH = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // command queue read side
  input  logic [$bits(cmd_ctrl_t)+3*(COORD_WIDTH+1)+3*(COORD_WIDTH+4)-1:0] cmd_i,
  input  logic                empty_i,
  output logic                pop_o,
  // pixel channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [OUT_XY_W-1:0] pixel_x_o,
  output logic [OUT_XY_W-1:0] pixel_y_o,
  output logic [COLOUR_W-1:0] pixel_colour_o,
  output logic                last_of_item_o,
  output logic                line_done_o
);

  localparam int POS_W = COORD_WIDTH + 1;
  localparam int DEC_W = COORD_WIDTH + 4;
  localparam int XW    = (POS_W > OUT_XY_W) ? POS_W : OUT_XY_W;

  // Unpack the command
  cmd_ctrl_t               c_ctrl;
  logic signed [POS_W-1:0] c_px, c_py, c_limit;
  logic signed [DEC_W-1:0] c_dec, c_keep, c_move;

  assign {c_ctrl, c_px, c_py, c_limit, c_dec, c_keep, c_move} = cmd_i;

  // Walk state
  logic signed [POS_W-1:0] walk_x_q, walk_y_q, limit_q;
  logic signed [DEC_W-1:0] dec_q, inc_keep_q, inc_move_q;
  octant_e                 oct_q;
  logic                    thick_q;
  logic [COLOUR_W-1:0]     colour_q;
  logic                    active_q;

  // Position waiting to go out
  logic                    pos_valid_q;
  logic signed [POS_W-1:0] pos_x_q, pos_y_q;
  logic                    pos_done_q;
  logic [SPAN_IDX_W-1:0]   span_idx_q;

  logic                    out_xfer, span_last, pos_free;

  assign span_last = !thick_q || (span_idx_q == SPAN_IDX_W'(SPAN_LEN - 1));
  assign out_xfer  = pos_valid_q && !out_stall_i;
  assign pos_free  = !pos_valid_q || (out_xfer && span_last);
  assign pop_o     = !empty_i && pos_free;

  // Next walk state for the popped command
  logic                    is_start, load_pos;
  logic                    c_shallow, s_shallow, minor;
  logic signed [POS_W-1:0] nx, ny, emit_x, emit_y;
  logic signed [DEC_W-1:0] ndec;
  logic                    ndone;

  always_comb begin
    is_start  = c_ctrl.kind == KIND_START;
    load_pos  = pop_o && (is_start || active_q);
    c_shallow = is_shallow(c_ctrl.octant);
    s_shallow = is_shallow(oct_q);
    minor     = dec_q[DEC_W-1] || (dec_q == '0);
    nx        = walk_x_q;
    ny        = walk_y_q;
    ndec      = dec_q;
    emit_x    = walk_x_q;
    emit_y    = walk_y_q;
    ndone     = 1'b0;
    if (is_start) begin
      nx     = c_px;
      ny     = c_py;
      emit_x = c_px;
      emit_y = c_py;
      // Thick walks begin one before the near end
      if (c_ctrl.thick && c_ctrl.octant != OCT_VERT) begin
        if (c_shallow) begin
          nx = c_px - POS_W'(1);
        end else begin
          ny = c_py - POS_W'(1);
        end
      end
      ndec  = c_dec;
      ndone = (c_shallow ? nx : ny) == c_limit;
    end else begin
      if (oct_q == OCT_VERT) begin
        ny = walk_y_q + POS_W'(1);
      end else begin
        ndec = dec_q + (minor ? inc_move_q : inc_keep_q);
        if (s_shallow) begin
          nx = walk_x_q + POS_W'(1);
          if (minor) begin
            ny = (oct_q == OCT_SHALLOW_DN) ? walk_y_q + POS_W'(1) : walk_y_q - POS_W'(1);
          end
        end else begin
          ny = walk_y_q + POS_W'(1);
          if (minor) begin
            nx = (oct_q == OCT_STEEP_DN) ? walk_x_q + POS_W'(1) : walk_x_q - POS_W'(1);
          end
        end
      end
      emit_x = nx;
      emit_y = ny;
      ndone  = (s_shallow ? nx : ny) == limit_q;
    end
  end

  // Control state: line activity and span sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      pos_valid_q <= 1'b0;
      span_idx_q  <= '0;
    end else begin
      if (load_pos) begin
        active_q <= !ndone;
      end
      if (pos_free) begin
        pos_valid_q <= load_pos;
        span_idx_q  <= '0;
      end else if (out_xfer) begin
        span_idx_q <= span_idx_q + SPAN_IDX_W'(1);
      end
    end
  end

  // Walk registers and the pending position
  always_ff @(posedge clk_i) begin
    if (pop_o && is_start) begin
      limit_q    <= c_limit;
      inc_keep_q <= c_keep;
      inc_move_q <= c_move;
      oct_q      <= c_ctrl.octant;
      thick_q    <= c_ctrl.thick;
      colour_q   <= c_ctrl.colour;
    end
    if (load_pos) begin
      walk_x_q   <= nx;
      walk_y_q   <= ny;
      dec_q      <= ndec;
      pos_x_q    <= emit_x;
      pos_y_q    <= emit_y;
      pos_done_q <= ndone;
    end
  end

  // Spread the position across the major axis
  logic signed [2:0]    off;
  logic signed [XW-1:0] ox, oy;

  always_comb begin
    off = thick_q ? span_offset(span_idx_q) : 3'sd0;
    ox  = XW'(pos_x_q);
    oy  = XW'(pos_y_q);
    if (is_shallow(oct_q)) begin
      oy = oy + XW'(off);
    end else begin
      ox = ox - XW'(off);
    end
  end

  assign out_valid_o    = pos_valid_q;
  assign pixel_x_o      = ox[OUT_XY_W-1:0];
  assign pixel_y_o      = oy[OUT_XY_W-1:0];
  assign pixel_colour_o = colour_q;
  assign last_of_item_o = span_last;
  assign line_done_o    = pos_done_q;

  // A pending position agrees with the line state
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_valid_q |-> (active_q == !pos_done_q))
    else $error("line activity disagrees with pending position");

  // Thin lines never leave the first span slot
  a_thin_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_valid_q && !thick_q) |-> (span_idx_q == '0))
    else $error("span index moved on a thin line");

  // The span index stays within a span
  a_span_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_valid_q |-> (span_idx_q <= SPAN_IDX_W'(SPAN_LEN - 1)))
    else $error("span index out of range");

  // A stalled pixel keeps its slot
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_valid_q && out_stall_i) |=> (pos_valid_q && $stable(span_idx_q)))
    else $error("pending pixel lost under stall");

endmodule

// ----- tb/tb_midpoint_line_rasterizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint line rasterizer testbench
// Feeds start and step items through a queue-driven driver. Each accepted
// item runs through a line walker written here, which queues the pixels the
// block must produce. A monitor checks every pixel transfer against the
// oldest queued pixel; both sides idle in random bursts before the last part.
// ----------------------------------------------------------------------------
module tb_midpoint_line_rasterizer;
  import mlr_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int COORD_MAX      = 2047;

  // One item as offered on the input channel
  typedef struct packed {
    kind_e               kind;
    logic [IN_W-1:0]     xs;
    logic [IN_W-1:0]     ys;
    logic [IN_W-1:0]     xe;
    logic [IN_W-1:0]     ye;
    logic [COLOUR_W-1:0] colour;
  } line_item_t;

  // One pixel as seen on the output channel
  typedef struct packed {
    logic [OUT_XY_W-1:0] x;
    logic [OUT_XY_W-1:0] y;
    logic [COLOUR_W-1:0] colour;
    logic                last;
    logic                done;
  } pixel_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic                cfg_wdata_i    = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic                kind_i         = KIND_START;
  logic [IN_W-1:0]     x_start_i      = '0;
  logic [IN_W-1:0]     y_start_i      = '0;
  logic [IN_W-1:0]     x_end_i        = '0;
  logic [IN_W-1:0]     y_end_i        = '0;
  logic [COLOUR_W-1:0] colour_i       = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [OUT_XY_W-1:0] pixel_x_o;
  logic [OUT_XY_W-1:0] pixel_y_o;
  logic [COLOUR_W-1:0] pixel_colour_o;
  logic                last_of_item_o;
  logic                line_done_o;

  line_item_t pending_items[$];
  pixel_t     expected_pixels[$];

  int errors       = 0;
  int stuck_cycles = 0;
  int send_gap     = 0;
  int stall_left   = 0;
  int hold_left    = 0;
  bit hold_req     = 1'b0;
  bit no_idle      = 1'b0;

  line_item_t cur_item;
  pixel_t     seen_px;
  pixel_t     want_px;

  // Mirror of the walker state; coordinates and decision terms stay well
  // inside their register widths, so plain integers track them exactly
  int                         walk_x, walk_y, major_end;
  int                         dec_val, inc_hold, inc_move;
  octant_e                    walk_oct;
  logic                       walking     = 1'b0;
  logic                       line_thick  = 1'b0;
  logic                       thick_reg   = 1'b0;
  logic [COLOUR_W-1:0]        line_colour = '0;

  midpoint_line_rasterizer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .x_start_i      (x_start_i),
    .y_start_i      (y_start_i),
    .x_end_i        (x_end_i),
    .y_end_i        (y_end_i),
    .colour_i       (colour_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .pixel_colour_o (pixel_colour_o),
    .last_of_item_o (last_of_item_o),
    .line_done_o    (line_done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Line walker
  // --------------------------------------------------------------------------
  function automatic logic walk_is_shallow();
    return (walk_oct == OCT_SHALLOW_DN) || (walk_oct == OCT_SHALLOW_UP);
  endfunction

  function automatic logic walk_at_end();
    return (walk_is_shallow() ? walk_x : walk_y) == major_end;
  endfunction

  function automatic int across_offset(input int k);
    case (k)
      1:       return 1;
      2:       return 2;
      3:       return -1;
      4:       return -2;
      default: return 0;
    endcase
  endfunction

  // Queue one walk position, widened to a span in thick mode
  function automatic void queue_position(input int px, input int py, input logic done);
    int     n;
    int     k;
    int     ox;
    int     oy;
    pixel_t p;
    n = line_thick ? int'(SPAN_LEN) : 1;
    for (k = 0; k < n; k++) begin
      ox = px;
      oy = py;
      if (line_thick) begin
        if (walk_is_shallow()) begin
          oy = py + across_offset(k);
        end else begin
          ox = px - across_offset(k);
        end
      end
      p.x      = ox[OUT_XY_W-1:0];
      p.y      = oy[OUT_XY_W-1:0];
      p.colour = line_colour;
      p.last   = (k == n - 1);
      p.done   = done;
      expected_pixels.push_back(p);
    end
    if (done) walking = 1'b0;
  endfunction

  // Order the endpoints, classify and set up the decision terms
  function automatic void begin_line(input line_item_t it);
    int x1, y1, x2, y2, a, b, px, py, t, lo, hi, lim;
    x1 = int'(it.xs);
    y1 = int'(it.ys);
    x2 = int'(it.xe);
    y2 = int'(it.ye);
    line_colour = it.colour;
    line_thick  = thick_reg;
    walking     = 1'b1;
    if (x2 < x1) begin
      t = x1; x1 = x2; x2 = t;
      t = y1; y1 = y2; y2 = t;
    end
    a = y2 - y1;
    b = x2 - x1;
    dec_val  = 0;
    inc_hold = 0;
    inc_move = 0;
    if (b == 0) begin
      lo = (y1 < y2) ? y1 : y2;
      hi = (y1 < y2) ? y2 : y1;
      walk_oct = OCT_VERT;
      px  = x1;
      py  = line_thick ? lo - 1 : lo;
      lim = line_thick ? hi + 1 : hi;
    end else begin
      px = x1;
      py = y1;
      if (a >= 0 && a <= b) begin
        walk_oct = OCT_SHALLOW_DN;
        dec_val  = b - 2 * a;
        inc_hold = -2 * a;
        inc_move = 2 * b - 2 * a;
        lim      = x2;
      end else if (a > b) begin
        walk_oct = OCT_STEEP_DN;
        dec_val  = a - 2 * b;
        inc_hold = -2 * b;
        inc_move = 2 * a - 2 * b;
        lim      = y2;
      end else if (a >= -b) begin
        walk_oct = OCT_SHALLOW_UP;
        dec_val  = 2 * a + b;
        inc_hold = 2 * a;
        inc_move = 2 * a + 2 * b;
        lim      = x2;
      end else begin
        // steep-up walks from the upper endpoint
        walk_oct = OCT_STEEP_UP;
        dec_val  = a + 2 * b;
        inc_hold = -2 * b;
        inc_move = -2 * a - 2 * b;
        px       = x2;
        py       = y2;
        lim      = y1;
      end
      if (line_thick) lim = lim + 1;
    end
    walk_x = px;
    walk_y = py;
    if (b != 0 && line_thick) begin
      if (walk_is_shallow()) begin
        walk_x = walk_x - 1;
      end else begin
        walk_y = walk_y - 1;
      end
    end
    major_end = lim;
    queue_position(px, py, walk_at_end());
  endfunction

  // One midpoint decision and one step on the major axis
  function automatic void advance_line();
    logic minor;
    if (!walking) return;
    if (walk_oct == OCT_VERT) begin
      walk_y = walk_y + 1;
    end else begin
      minor   = !(dec_val > 0);
      dec_val = dec_val + (minor ? inc_move : inc_hold);
      if (walk_is_shallow()) begin
        if (minor) walk_y = walk_y + ((walk_oct == OCT_SHALLOW_DN) ? 1 : -1);
        walk_x = walk_x + 1;
      end else begin
        if (minor) walk_x = walk_x + ((walk_oct == OCT_STEEP_DN) ? 1 : -1);
        walk_y = walk_y + 1;
      end
    end
    queue_position(walk_x, walk_y, walk_at_end());
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present queued items, hold while stalled, idle in bursts
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      if (cur_item.kind == KIND_START) begin
        begin_line(cur_item);
      end else begin
        advance_line();
      end
      if (!no_idle && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 14);
    end
    if (in_valid_i && in_stall_o) begin
      // hold the stalled payload
    end else if (send_gap > 0) begin
      send_gap = send_gap - 1;
      in_valid_i <= 1'b0;
    end else if (pending_items.size() > 0) begin
      cur_item = pending_items.pop_front();
      kind_i     <= cur_item.kind;
      x_start_i  <= cur_item.xs;
      y_start_i  <= cur_item.ys;
      x_end_i    <= cur_item.xe;
      y_end_i    <= cur_item.ye;
      colour_i   <= cur_item.colour;
      in_valid_i <= 1'b1;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each pixel transfer, drive stall
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      seen_px.x      = pixel_x_o;
      seen_px.y      = pixel_y_o;
      seen_px.colour = pixel_colour_o;
      seen_px.last   = last_of_item_o;
      seen_px.done   = line_done_o;
      if (expected_pixels.size() == 0) begin
        if (errors < 10) begin
          $display("unexpected pixel: x=%h y=%h colour=%h last=%b done=%b",
                   seen_px.x, seen_px.y, seen_px.colour, seen_px.last, seen_px.done);
        end
        errors = errors + 1;
      end else begin
        want_px = expected_pixels.pop_front();
        if (seen_px !== want_px) begin
          if (errors < 10) begin
            $display("pixel mismatch: expected x=%h y=%h colour=%h last=%b done=%b",
                     want_px.x, want_px.y, want_px.colour, want_px.last, want_px.done);
            $display("                got      x=%h y=%h colour=%h last=%b done=%b",
                     seen_px.x, seen_px.y, seen_px.colour, seen_px.last, seen_px.done);
          end
          errors = errors + 1;
        end
      end
    end
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (!no_idle && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 14);
    end
  end

  // Abort when no transfer happens on either channel for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles = stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic line_item_t random_item();
    line_item_t it;
    it.kind   = KIND_STEP;
    it.xs     = IN_W'($urandom);
    it.ys     = IN_W'($urandom);
    it.xe     = IN_W'($urandom);
    it.ye     = IN_W'($urandom);
    it.colour = COLOUR_W'($urandom);
    return it;
  endfunction

  function automatic void add_step();
    pending_items.push_back(random_item());
  endfunction

  function automatic void add_line(input int xs, input int ys, input int xe, input int ye,
                                   input int colour, input int nsteps);
    line_item_t it;
    int         k;
    it        = random_item();
    it.kind   = KIND_START;
    it.xs     = IN_W'(xs);
    it.ys     = IN_W'(ys);
    it.xe     = IN_W'(xe);
    it.ye     = IN_W'(ye);
    it.colour = COLOUR_W'(colour);
    pending_items.push_back(it);
    for (k = 0; k < nsteps; k++) add_step();
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // Mostly complete short lines, plus abandoned lines, overruns and lone steps
  function automatic void add_random_lines(input int target);
    int count, r, r2, span, xs, ys, xe, ye, ext, nsteps;
    count = 0;
    while (count < target) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        add_step();
        count = count + 1;
      end else begin
        xs = $urandom_range(0, COORD_MAX);
        ys = $urandom_range(0, COORD_MAX);
        if (r < 16) begin
          // far endpoints, walked a little and then dropped
          xe     = $urandom_range(0, COORD_MAX);
          ye     = $urandom_range(0, COORD_MAX);
          nsteps = $urandom_range(0, 3);
          ext    = nsteps;
        end else begin
          span = (r < 22) ? 40 : 6;
          xe   = (r < 30) ? xs : clamp_coord(xs + $urandom_range(0, 2 * span) - span);
          ye   = clamp_coord(ys + $urandom_range(0, 2 * span) - span);
          ext  = (xe > xs) ? xe - xs : xs - xe;
          if (((ye > ys) ? ye - ys : ys - ye) > ext) ext = (ye > ys) ? ye - ys : ys - ye;
          if (thick_reg) ext = ext + 2;
          nsteps = ext;
          r2 = $urandom_range(0, 9);
          if (r2 == 0) begin
            nsteps = $urandom_range(0, ext);
            ext    = nsteps;
          end else if (r2 == 1) begin
            nsteps = ext + $urandom_range(1, 2);
          end
        end
        add_line(xs, ys, xe, ye, $urandom, nsteps);
        count = count + 1 + ext;
      end
    end
  endfunction

  // Wait for every item and pixel to drain, then let the pipeline settle
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || expected_pixels.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_thick(input logic value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    thick_reg = value;
    @(negedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed thin lines: idle step, single point, every class, restart
    write_thick(1'b0);
    add_step();
    add_line(0, 0, 0, 0, 24'h000000, 1);
    add_line(COORD_MAX, 2, COORD_MAX, 1, 24'hFFFFFF, 1);
    add_line(0, 0, 2, 1, 24'h123456, 2);
    add_line(COORD_MAX, COORD_MAX, 2046, 2044, 24'hA5A5A5, 1);
    add_line(0, COORD_MAX, 2, 2046, 24'h5A5A5A, 2);
    add_line(5, 8, 6, 6, 24'hC0FFEE, 2);
    wait_drained();

    // Directed thick lines at the edges of the coordinate range
    write_thick(1'b1);
    add_line(0, 1, 0, 0, 24'h0F0F0F, 3);
    add_line(2046, COORD_MAX, COORD_MAX, COORD_MAX, 24'hF0F0F0, 3);
    wait_drained();

    // Random thin lines with a long receiver hold-off
    write_thick(1'b0);
    add_random_lines(15);
    hold_req = 1'b1;
    wait_drained();

    write_thick(1'b1);
    add_random_lines(15);
    wait_drained();

    write_thick(1'b0);
    add_random_lines(15);
    wait_drained();

    // Last part: no idling, plus one full-width thick line walked a few steps
    no_idle = 1'b1;
    write_thick(1'b1);
    add_random_lines(15);
    add_line(0, 0, COORD_MAX, 1023, $urandom, 4);
    wait_drained();

    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
